>>> rtl/core/lsmt_pkg.sv
// Shared types and constants for the LCD scanline and mode timing block.
`default_nettype none

package lsmt_pkg;

  localparam int LINE_LAST_DOT_DEF = 113;
  localparam int VISIBLE_LINES_DEF = 144;

  // Vblank lines following the first vblank line before the frame wraps.
  localparam int VBLANK_EXTRA_LINES = 9;

  localparam logic [6:0] DOT_TRANSFER = 7'd19;
  localparam logic [6:0] DOT_HBLANK   = 7'd61;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [7:0] line;
    logic [1:0] mode;
    logic [6:0] dot_count;
    logic       coincidence;
    logic       stat_request;
    logic       vblank_request;
    logic       render_line_now;
    logic       render_frame_now;
  } lsmt_result_t;

endpackage

`default_nettype wire

>>> rtl/core/lsmt_in_stage.sv
// Input register stage holding one line-compare beat.
`default_nettype none

module lsmt_in_stage
  import lsmt_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [IN_DATA_W-1:0] in_data,
  input  wire logic                 advance,
  output logic                      held_valid,
  output logic [7:0]                held_lyc
);

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_lyc <= in_data[7:0];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lsmt_timing.sv
// Dot, line and mode counters with the per-tick result logic.
`default_nettype none

module lsmt_timing
  import lsmt_pkg::*;
#(
  parameter int LINE_LAST_DOT = LINE_LAST_DOT_DEF,
  parameter int VISIBLE_LINES = VISIBLE_LINES_DEF
)
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] lyc,
  output lsmt_result_t    result
);

  localparam logic [6:0] LAST_DOT  = 7'(LINE_LAST_DOT);
  localparam logic [7:0] VIS_LINE  = 8'(VISIBLE_LINES);
  localparam logic [7:0] LAST_LINE = 8'(VISIBLE_LINES + VBLANK_EXTRA_LINES);

  logic [6:0] dot_counter;
  logic [7:0] line_counter;
  logic [1:0] mode_bits;

  logic [6:0] dot_counter_next;
  logic [7:0] line_counter_next;
  logic [1:0] mode_bits_next;
  logic       last_dot;
  logic       rline;
  logic       rframe;

  assign last_dot = (dot_counter == LAST_DOT);

  always_comb begin
    line_counter_next = line_counter;
    mode_bits_next    = mode_bits;
    rline             = 1'b0;
    rframe            = 1'b0;
    if (line_counter < VIS_LINE) begin
      if (dot_counter == 7'd0) begin
        mode_bits_next = MODE_OAM;
      end else if (dot_counter == DOT_TRANSFER) begin
        mode_bits_next = MODE_XFER;
      end
      if (dot_counter == DOT_HBLANK) begin
        mode_bits_next = MODE_HBLANK;
        rline          = 1'b1;
      end
      // A new visible line always opens with the OAM scan.
      if (last_dot) begin
        line_counter_next = line_counter + 8'd1;
        mode_bits_next    = MODE_OAM;
      end
    end else if (line_counter == VIS_LINE) begin
      mode_bits_next = MODE_VBLANK;
      if (last_dot) begin
        rframe            = 1'b1;
        line_counter_next = line_counter + 8'd1;
      end
    end else if (line_counter >= LAST_LINE) begin
      if (last_dot) begin
        line_counter_next = 8'd0;
      end
    end else if (last_dot) begin
      line_counter_next = line_counter + 8'd1;
    end
    dot_counter_next = (dot_counter >= LAST_DOT) ? 7'd0 : dot_counter + 7'd1;
  end

  always_comb begin
    result.line             = line_counter_next;
    result.mode             = mode_bits_next;
    result.dot_count        = dot_counter;
    result.coincidence      = (lyc == line_counter_next);
    result.stat_request     = (lyc == line_counter_next);
    result.vblank_request   = rframe;
    result.render_line_now  = rline;
    result.render_frame_now = rframe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_counter  <= 7'd0;
      line_counter <= 8'd0;
      mode_bits    <= MODE_HBLANK;
    end else if (step) begin
      dot_counter  <= dot_counter_next;
      line_counter <= line_counter_next;
      mode_bits    <= mode_bits_next;
    end
  end

`ifndef SYNTHESIS
  a_dot_in_range: assert property (@(posedge clk) disable iff (rst)
    dot_counter <= LAST_DOT)
    else $error("dot counter ran past the last dot");

  a_line_in_range: assert property (@(posedge clk) disable iff (rst)
    line_counter <= LAST_LINE)
    else $error("line counter ran past the last vblank line");

  a_dot_wrap: assert property (@(posedge clk) disable iff (rst)
    step && last_dot |=> dot_counter == 7'd0 && line_counter != $past(line_counter))
    else $error("line did not advance at the last dot");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    step && line_counter == VIS_LINE |=> mode_bits == MODE_VBLANK)
    else $error("first vblank line did not enter vblank mode");
`endif

endmodule

`default_nettype wire

>>> rtl/core/lsmt_out_stage.sv
// Output register that holds one result beat until the receiver takes it.
`default_nettype none

module lsmt_out_stage
  import lsmt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire lsmt_result_t          result,
  output logic                       advance,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_DATA_W-1:0]      out_data
);

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      out_data <= {2'b00, result.render_frame_now, result.render_line_now,
                   result.vblank_request, result.stat_request, result.coincidence,
                   result.dot_count, result.mode, result.line};
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lcd_scanline_mode_timing.sv
// Top level of the LCD scanline and mode timing generator.
//
// Each beat on the s_axis channel is one machine-cycle tick carrying the
// line-compare value (LYC). For every tick the block returns one beat on the
// m_axis channel with the line and mode after the tick, the dot position
// before it, the coincidence flag, the status request and the vblank,
// render-line and render-frame pulses.
// A tick passes through an input register and the counter update into an
// output register. Unless the receiver stalls, one tick is accepted every
// cycle; the throughput of one beat per cycle is set by the single
// dot/line/mode counter update done per accepted tick.
// The counters advance only on accepted ticks, so gaps in the input stream
// do not move display timing.
// When the receiver stalls, the output register holds its beat. If the input
// register is full, s_axis_tready drops in the same cycle; if it is empty, it
// takes one more tick first and then s_axis_tready drops.
// Reset (rst, synchronous, active high) clears both stages and sets the
// dot and line counters to zero with the mode at hblank.
`default_nettype none

module lcd_scanline_mode_timing
  import lsmt_pkg::*;
#(
  parameter int LINE_LAST_DOT = LINE_LAST_DOT_DEF,
  parameter int VISIBLE_LINES = VISIBLE_LINES_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] line_compare
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [7:0] line, [9:8] mode, [16:10] dot_count, [17] coincidence,
  // [18] stat_request, [19] vblank_request, [20] render_line_now,
  // [21] render_frame_now, [23:22] zero
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  logic         advance;
  logic         held_valid;
  logic [7:0]   held_lyc;
  logic         step;
  lsmt_result_t result;

  assign step = held_valid && advance;

  lsmt_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .advance    (advance),
    .held_valid (held_valid),
    .held_lyc   (held_lyc)
  );

  lsmt_timing #(
    .LINE_LAST_DOT (LINE_LAST_DOT),
    .VISIBLE_LINES (VISIBLE_LINES)
  ) u_timing (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .lyc    (held_lyc),
    .result (result)
  );

  lsmt_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .result    (result),
    .advance   (advance),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the LCD scanline and mode timing generator.
`timescale 1ns / 100ps

module tb_top;
  import lsmt_pkg::*;

  localparam int LAST_DOT   = LINE_LAST_DOT_DEF;
  localparam int VIS_LINES  = VISIBLE_LINES_DEF;
  localparam int FRAME_LAST = VISIBLE_LINES_DEF + VBLANK_EXTRA_LINES;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 10;

  // Output beat as it sits in m_axis_tdata, line in the lowest bits.
  typedef struct packed {
    logic       render_frame_now;
    logic       render_line_now;
    logic       vblank_request;
    logic       stat_request;
    logic       coincidence;
    logic [6:0] dot_count;
    logic [1:0] mode;
    logic [7:0] line;
  } timing_beat_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Predicted display timing state.
  logic [6:0] dot_pos;
  logic [7:0] scan_line;
  logic [1:0] lcd_mode;
  int         frames_done;

  timing_beat_t expected_beats[$];
  int           idle_pct = 0;
  int           error_count = 0;
  int           cycle_count = 0;

  lcd_scanline_mode_timing i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic clear_timing();
    dot_pos     = '0;
    scan_line   = '0;
    lcd_mode    = MODE_HBLANK;
    frames_done = 0;
  endtask

  // Advances the predicted counters by one tick and queues the beat it yields.
  task automatic advance_timing(input logic [7:0] lyc);
    timing_beat_t beat;
    logic         at_last;
    logic [7:0]   nxt_line;
    logic [1:0]   nxt_mode;
    beat     = '0;
    at_last  = (dot_pos == LAST_DOT);
    nxt_line = scan_line;
    nxt_mode = lcd_mode;
    if (scan_line < VIS_LINES) begin
      if (dot_pos == 0)
        nxt_mode = MODE_OAM;
      else if (dot_pos == DOT_TRANSFER)
        nxt_mode = MODE_XFER;
      if (dot_pos == DOT_HBLANK) begin
        nxt_mode = MODE_HBLANK;
        beat.render_line_now = 1'b1;
      end
      if (at_last) begin
        nxt_line = scan_line + 8'd1;
        nxt_mode = MODE_OAM;
      end
    end else if (scan_line == VIS_LINES) begin
      nxt_mode = MODE_VBLANK;
      if (at_last) begin
        beat.render_frame_now = 1'b1;
        beat.vblank_request   = 1'b1;
        nxt_line = scan_line + 8'd1;
      end
    end else if (scan_line >= FRAME_LAST) begin
      if (at_last) begin
        nxt_line = '0;
        frames_done++;
      end
    end else if (at_last) begin
      nxt_line = scan_line + 8'd1;
    end
    beat.line         = nxt_line;
    beat.mode         = nxt_mode;
    beat.dot_count    = dot_pos;
    beat.coincidence  = (lyc == nxt_line);
    beat.stat_request = beat.coincidence;
    expected_beats.push_back(beat);
    dot_pos   = (dot_pos >= LAST_DOT) ? 7'd0 : dot_pos + 7'd1;
    scan_line = nxt_line;
    lcd_mode  = nxt_mode;
  endtask

  // Offers one tick, with a random gap ahead of it, and records it once taken.
  task automatic send_tick(input logic [7:0] lyc);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= lyc;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    advance_timing(lyc);
  endtask

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    timing_beat_t got;
    timing_beat_t exp_beat;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = timing_beat_t'(m_axis_tdata[21:0]);
      if (expected_beats.size() == 0) begin
        $error("unexpected output beat 0x%06h", m_axis_tdata);
        error_count++;
      end else begin
        exp_beat = expected_beats.pop_front();
        check_field("line", exp_beat.line, got.line);
        check_field("mode", exp_beat.mode, got.mode);
        check_field("dot_count", exp_beat.dot_count, got.dot_count);
        check_field("coincidence", exp_beat.coincidence, got.coincidence);
        check_field("stat_request", exp_beat.stat_request, got.stat_request);
        check_field("vblank_request", exp_beat.vblank_request, got.vblank_request);
        check_field("render_line_now", exp_beat.render_line_now, got.render_line_now);
        check_field("render_frame_now", exp_beat.render_frame_now,
                    got.render_frame_now);
        check_field("pad", 0, m_axis_tdata[23:22]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Compare values at the ends of the range and walking bits, from reset.
  task automatic test_compare_extremes();
    logic [7:0] lyc_list[$];
    lyc_list = '{8'h00, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE,
                 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h99, 8'h98, 8'h90,
                 8'h00, 8'hFF};
    idle_pct = 0;
    foreach (lyc_list[i]) send_tick(lyc_list[i]);
  endtask

  // Walks on until the frame has wrapped twice so that every line, the vblank entry,
  // the vblank pulses and the frame wrap are all hit. The first frame runs without gaps.
  task automatic test_frame_walk();
    int         pick;
    logic [7:0] lyc;
    while (frames_done < 2) begin
      idle_pct = (frames_done == 0) ? 0 : 30;
      pick = $urandom_range(99);
      if (pick < 40)
        lyc = scan_line;
      else if (pick < 50)
        lyc = scan_line + 8'd1;
      else
        lyc = 8'($urandom_range(255));
      send_tick(lyc);
    end
  endtask

  // Random compare values with gaps on both sides.
  task automatic test_random_ticks();
    logic [7:0] lyc;
    idle_pct = 30;
    repeat (1200) begin
      lyc = ($urandom_range(3) == 0) ? scan_line : 8'($urandom_range(255));
      send_tick(lyc);
    end
  endtask

  initial begin
    clear_timing();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_compare_extremes();
    test_frame_walk();
    test_random_ticks();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lsmt_pkg.sv
rtl/core/lsmt_in_stage.sv
rtl/core/lsmt_timing.sv
rtl/core/lsmt_out_stage.sv
rtl/core/lcd_scanline_mode_timing.sv
dv/tb_top.sv
